// ===== hdl/tcm_pkg.sv =====
package tcm_pkg;

  // Field widths
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned TEMP_W  = 11;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned NUM_CH  = 4;

  // APB register map, word index taken from paddr[3:2]
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam logic [1:0]  REG_HIGH_LIMIT   = 2'd0;
  localparam logic [1:0]  REG_LOW_LIMIT    = 2'd1;
  localparam logic [1:0]  REG_ALARM_ENABLE = 2'd2;

  // Register reset values
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 7'd40;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 7'd10;
  localparam logic               ENABLE_RST     = 1'b1;

  // Temperature correction constants, tenths of a degree
  localparam logic [RAW_W-1:0]  TEMP_OFFSET = 16'd5;
  localparam logic [RAW_W-1:0]  CLAMP_EDGE  = 16'd1205;  // offset + clamp
  localparam logic [TEMP_W-1:0] TEMP_CLAMP  = 11'd1200;

  // Limits scaled to tenths, so degree compares need no divide
  typedef struct packed {
    logic              enable;
    logic [TEMP_W-1:0] high_thr;      // 10 * high_limit
    logic [TEMP_W-1:0] chan_low_thr;  // 10 * (low_limit + 1)
    logic [TEMP_W-1:0] mean_low_thr;  // 10 * low_limit
  } cfg_t;

endpackage

// ===== hdl/tcm_apb_regs.sv =====
module tcm_apb_regs
  import tcm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [LIMIT_W-1:0] high_limit_q;
  logic [LIMIT_W-1:0] low_limit_q;
  logic               enable_q;
  logic               wr_en;
  logic [7:0]         low_plus_one;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_limit_q <= HIGH_LIMIT_RST;
      low_limit_q  <= LOW_LIMIT_RST;
      enable_q     <= ENABLE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_HIGH_LIMIT:   high_limit_q <= pwdata[LIMIT_W-1:0];
        REG_LOW_LIMIT:    low_limit_q  <= pwdata[LIMIT_W-1:0];
        REG_ALARM_ENABLE: enable_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_HIGH_LIMIT:   prdata = {{(DATA_W-LIMIT_W){1'b0}}, high_limit_q};
      REG_LOW_LIMIT:    prdata = {{(DATA_W-LIMIT_W){1'b0}}, low_limit_q};
      REG_ALARM_ENABLE: prdata = {{(DATA_W-1){1'b0}}, enable_q};
      default:          prdata = '0;
    endcase
  end

  // Scale limits to tenths with shift-add (x*10 = x*8 + x*2)
  assign low_plus_one = {1'b0, low_limit_q} + 8'd1;

  always_comb begin
    cfg_o.enable       = enable_q;
    cfg_o.high_thr     = {1'b0, high_limit_q, 3'b000} + {3'b000, high_limit_q, 1'b0};
    cfg_o.chan_low_thr = {low_plus_one, 3'b000} + {2'b00, low_plus_one, 1'b0};
    cfg_o.mean_low_thr = {1'b0, low_limit_q, 3'b000} + {3'b000, low_limit_q, 1'b0};
  end

endmodule

// ===== hdl/tcm_channel.sv =====
module tcm_channel
  import tcm_pkg::*;
(
  input  logic [RAW_W-1:0]  raw_i,
  input  cfg_t              cfg_i,
  output logic [TEMP_W-1:0] temp_o,
  output logic              alarm_o
);

  logic [RAW_W+3:0] scaled_full;
  logic [RAW_W-1:0] scaled;
  logic [RAW_W-1:0] diff;

  // Round raw * 0.625 half up: (raw*10 + 8) >> 4
  assign scaled_full = {1'b0, raw_i, 3'b000} + {3'b000, raw_i, 1'b0} + 20'd8;
  assign scaled      = scaled_full[RAW_W+3:4];
  assign diff        = scaled - TEMP_OFFSET;

  // Drop the offset; wrapped or hot readings clamp to the ceiling
  always_comb begin
    if (scaled < TEMP_OFFSET || scaled > CLAMP_EDGE) begin
      temp_o = TEMP_CLAMP;
    end else begin
      temp_o = diff[TEMP_W-1:0];
    end
  end

  // Degree compares done in tenths against pre-scaled limits
  assign alarm_o = cfg_i.enable &
                   ((temp_o >= cfg_i.high_thr) | (temp_o < cfg_i.chan_low_thr));

endmodule

// ===== hdl/four_channel_temperature_monitor_core.sv =====
// Four-channel temperature monitor.
// Input channel: in_valid_i / in_stall_o carry one word of four raw 16-bit
// sensor readings (1/16 degree per count). Output channel: out_valid_o /
// out_stall_i carry one result word per input word: four corrected
// temperatures and their mean in tenths of a degree, per-channel alarms,
// mean high/low flags and a buzzer request.
// An accepted word passes one input register, then one result register, with
// the correction, mean and compares between them; out_valid_o rises when the
// word is loaded into the result register.
// Throughput is one word per cycle from the two-stage pipeline unless stalled.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; in_stall_o rises only when both stages
// are full and the output is stalled.
// The APB port sets high_limit (0x0), low_limit (0x4) and alarm_enable (0x8);
// write it only while no word is in flight.
// Reset empties both stages and loads the limits 40 and 10 degrees with
// monitoring enabled.
module four_channel_temperature_monitor_core
  import tcm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [RAW_W-1:0]    raw_zero_i,
  input  logic [RAW_W-1:0]    raw_one_i,
  input  logic [RAW_W-1:0]    raw_two_i,
  input  logic [RAW_W-1:0]    raw_three_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TEMP_W-1:0]   temp_zero_o,
  output logic [TEMP_W-1:0]   temp_one_o,
  output logic [TEMP_W-1:0]   temp_two_o,
  output logic [TEMP_W-1:0]   temp_three_o,
  output logic [TEMP_W-1:0]   temp_mean_o,
  output logic [NUM_CH-1:0]   channel_alarms_o,
  output logic                mean_high_o,
  output logic                mean_low_o,
  output logic                buzzer_request_o
);

  cfg_t cfg;

  logic                 in_valid_q;
  logic [RAW_W-1:0]     raw_q   [NUM_CH];
  logic [RAW_W-1:0]     raw_in  [NUM_CH];
  logic [TEMP_W-1:0]    temp    [NUM_CH];
  logic [NUM_CH-1:0]    alarms;
  logic [TEMP_W+1:0]    sum;
  logic [TEMP_W-1:0]    mean;
  logic                 mean_high;
  logic                 mean_low;
  logic                 out_adv;
  logic                 in_adv;

  logic                 out_valid_q;
  logic [TEMP_W-1:0]    temp_q  [NUM_CH];
  logic [TEMP_W-1:0]    mean_q;
  logic [NUM_CH-1:0]    alarms_q;
  logic                 mean_high_q;
  logic                 mean_low_q;
  logic                 buzzer_q;

  tcm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline handshake: each stage advances when the next one frees up
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  assign raw_in[0] = raw_zero_i;
  assign raw_in[1] = raw_one_i;
  assign raw_in[2] = raw_two_i;
  assign raw_in[3] = raw_three_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      raw_q <= raw_in;
    end
  end

  // Per-channel correction and alarm
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    tcm_channel u_ch (
      .raw_i   (raw_q[c]),
      .cfg_i   (cfg),
      .temp_o  (temp[c]),
      .alarm_o (alarms[c])
    );
  end

  // Truncated mean and its flags
  assign sum  = {2'b00, temp[0]} + {2'b00, temp[1]} + {2'b00, temp[2]} + {2'b00, temp[3]};
  assign mean = sum[TEMP_W+1:2];

  assign mean_high = cfg.enable & (mean >= cfg.high_thr);
  assign mean_low  = cfg.enable & !(mean >= cfg.high_thr) & (mean < cfg.mean_low_thr);

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      temp_q      <= temp;
      mean_q      <= mean;
      alarms_q    <= alarms;
      mean_high_q <= mean_high;
      mean_low_q  <= mean_low;
      buzzer_q    <= (|alarms) | mean_high | mean_low;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign temp_zero_o      = temp_q[0];
  assign temp_one_o       = temp_q[1];
  assign temp_two_o       = temp_q[2];
  assign temp_three_o     = temp_q[3];
  assign temp_mean_o      = mean_q;
  assign channel_alarms_o = alarms_q;
  assign mean_high_o      = mean_high_q;
  assign mean_low_o       = mean_low_q;
  assign buzzer_request_o = buzzer_q;

endmodule
